### sv/qr_byte_mode_codeword_builder_defines.svh
// Assertion macros for the QR byte-mode codeword builder.
// Included by the top level; depends on nothing else.
`ifndef QR_BYTE_MODE_CODEWORD_BUILDER_DEFINES_SVH
`define QR_BYTE_MODE_CODEWORD_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QRBCW_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QRBCW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/qrbcw_pkg.sv
// Shared types, constants and the version table for the QR codeword builder.
// Depends on nothing; used by the top level, front, queue and back.
`default_nettype none

package qrbcw_pkg;

  localparam int VERSION_COUNT = 40;
  localparam int MAX_VERSION   = 40;

  localparam logic [3:0] MODE_BYTE = 4'h4;
  localparam logic [7:0] PAD_A     = 8'hEC;
  localparam logic [7:0] PAD_B     = 8'h11;

  localparam logic [11:0] CAP_CW [VERSION_COUNT] = '{
    16, 28, 44, 64, 86, 108, 124, 154, 182, 216,
    254, 290, 334, 365, 415, 453, 507, 563, 627, 669,
    714, 782, 860, 914, 1000, 1062, 1128, 1193, 1267, 1373,
    1455, 1541, 1631, 1725, 1812, 1914, 1992, 2102, 2216, 2334
  };

  localparam logic [5:0] SHORT_LEN [VERSION_COUNT] = '{
    16, 28, 44, 32, 43, 27, 31, 38, 36, 43,
    50, 36, 37, 40, 41, 45, 46, 43, 44, 41,
    42, 46, 47, 45, 47, 46, 45, 45, 45, 47,
    46, 46, 46, 46, 47, 47, 46, 46, 47, 47
  };

  localparam logic [5:0] SHORT_BLOCKS [VERSION_COUNT] = '{
    1, 1, 1, 2, 2, 4, 4, 2, 3, 4,
    1, 6, 8, 4, 5, 7, 10, 9, 3, 3,
    17, 17, 4, 6, 8, 19, 22, 3, 21, 19,
    2, 10, 14, 14, 12, 6, 29, 13, 40, 18
  };

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_PAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_LONG,
    ST_ORDER
  } status_t;

  typedef struct packed {
    logic [5:0]  version;
    logic [11:0] cap;
    logic [5:0]  short_len;
    logic [5:0]  short_blocks;
  } geom_t;

  typedef struct packed {
    status_t         status;
    logic [1:0]      count;
    logic            last;
    logic [2:0][7:0] cw;
  } qentry_t;

  function automatic geom_t geom_of(logic [11:0] len);
    geom_t       g;
    logic        found;
    logic [12:0] need;
    g     = '0;
    found = 1'b0;
    for (int v = 0; v < MAX_VERSION; v++) begin
      need = {1'b0, len} + ((v < 9) ? 13'd2 : 13'd3);
      if (!found && (need <= {1'b0, CAP_CW[v]})) begin
        found          = 1'b1;
        g.version      = 6'(v + 1);
        g.cap          = CAP_CW[v];
        g.short_len    = SHORT_LEN[v];
        g.short_blocks = SHORT_BLOCKS[v];
      end
    end
    return g;
  endfunction

endpackage

`default_nettype wire

### sv/qrbcw_in_if.sv
// Request channel: valid/ready handshake carrying one request beat.
// Depends on nothing.
`default_nettype none

interface qrbcw_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

`default_nettype wire

### sv/qrbcw_out_if.sv
// Codeword channel: valid/ready handshake carrying one tagged codeword beat.
// Depends on nothing.
`default_nettype none

interface qrbcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] codeword;
  logic [5:0] block_index;
  logic [5:0] position_in_block;
  logic [5:0] symbol_version;
  logic       last;
  logic [1:0] status;

  modport source (output valid, codeword, block_index, position_in_block,
                  symbol_version, last, status, input ready);
  modport sink (input valid, codeword, block_index, position_in_block,
                symbol_version, last, status, output ready);
endinterface

`default_nettype wire

### sv/qr_byte_mode_codeword_builder.sv
// Top level of the QR byte-mode level-M codeword builder.
// Depends on qrbcw_pkg, both channel interfaces, front, queue, back and the defines.
//
//   Channel      Direction  Beat content
//   in_ch        sink       req_type, data_byte
//   out_ch       source     codeword, block_index, position_in_block,
//                           symbol_version, last, status
//   cfg_wr_*     write      message_length (12 bits)
//
// One request is taken per cycle unless q_full; each request yields one codeword beat,
// except the first of a message, which yields two or three, one per cycle from the single
// output register. The two-entry queue lets the front end take requests while the output
// stalls. Reset is synchronous and active high; a message_length write restarts the message.
`default_nettype none

`include "qr_byte_mode_codeword_builder_defines.svh"

module qr_byte_mode_codeword_builder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  qrbcw_in_if.sink         in_ch,
  qrbcw_out_if.source      out_ch
);

  logic [11:0]        message_length;
  qrbcw_pkg::geom_t   geom;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  qrbcw_pkg::qentry_t q_entry;
  qrbcw_pkg::qentry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= '0;
      geom           <= qrbcw_pkg::geom_of(12'd0);
    end else if (cfg_wr_en) begin
      message_length <= cfg_wr_data;
      geom           <= qrbcw_pkg::geom_of(cfg_wr_data);
    end
  end

  qrbcw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr_en),
    .msg_len (message_length),
    .geom    (geom),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  qrbcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  qrbcw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr_en),
    .geom    (geom),
    .q_empty (q_empty),
    .head    (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `QRBCW_ASSERT_NOW(a_err_untagged, clk, rst, out_ch.valid && (out_ch.status != qrbcw_pkg::ST_OK), !out_ch.last && (out_ch.block_index == 6'd0) && (out_ch.position_in_block == 6'd0), "Error beat carries block tags.")
  `QRBCW_ASSERT_NOW(a_ok_has_version, clk, rst, out_ch.valid && (out_ch.status == qrbcw_pkg::ST_OK), out_ch.symbol_version != 6'd0, "Good codeword without a version.")
  `QRBCW_ASSERT_NOW(a_pos_in_range, clk, rst, out_ch.valid && (out_ch.status == qrbcw_pkg::ST_OK), out_ch.position_in_block <= geom.short_len, "Position beyond block length.")
  `QRBCW_ASSERT_NEXT(a_pop_frees, clk, rst, q_full && q_pop && !cfg_wr_en, !q_full, "Queue stays full after a pop.")

endmodule

`default_nettype wire

### sv/qrbcw_front.sv
// Front end: accepts request beats, checks their order and forms the codewords.
// Depends on qrbcw_pkg and qrbcw_in_if.
`default_nettype none

module qrbcw_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              restart,
  input  wire logic [11:0]       msg_len,
  input  wire qrbcw_pkg::geom_t  geom,
  qrbcw_in_if.sink               in_ch,
  input  wire logic              q_full,
  output logic                   q_push,
  output qrbcw_pkg::qentry_t     q_entry
);

  qrbcw_pkg::phase_t phase, phase_next;
  logic [11:0] bytes_seen, bytes_seen_next;
  logic [11:0] cws_sent, cws_sent_next;
  logic [3:0]  carry, carry_next;
  logic        pad_toggle, pad_toggle_next;

  logic        accept;
  logic        seq_ok;
  logic        do_step;
  logic [1:0]  hdr_n;
  logic [1:0]  cw_count;
  logic [3:0]  carry_eff;
  logic [7:0]  body_cw;
  logic [12:0] cw_sum;
  logic        is_last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  always_comb begin
    unique case (phase)
      qrbcw_pkg::PH_DONE:   seq_ok = 1'b0;
      qrbcw_pkg::PH_PAD:    seq_ok = in_ch.req_type;
      qrbcw_pkg::PH_HEADER,
      qrbcw_pkg::PH_BODY:   seq_ok = in_ch.req_type ? (bytes_seen >= msg_len)
                                                    : (bytes_seen < msg_len);
    endcase
  end

  always_comb begin
    hdr_n     = (phase == qrbcw_pkg::PH_HEADER) ?
                ((geom.version <= 6'd9) ? 2'd1 : 2'd2) : 2'd0;
    carry_eff = (phase == qrbcw_pkg::PH_HEADER) ? msg_len[3:0] : carry;
    if (phase == qrbcw_pkg::PH_PAD) begin
      body_cw = pad_toggle ? qrbcw_pkg::PAD_B : qrbcw_pkg::PAD_A;
    end else if (in_ch.req_type) begin
      body_cw = {carry_eff, 4'h0};
    end else begin
      body_cw = {carry_eff, in_ch.data_byte[7:4]};
    end
    cw_count = hdr_n + 2'd1;
    cw_sum   = {1'b0, cws_sent} + {11'd0, cw_count};
    is_last  = (cw_sum == {1'b0, geom.cap});
    do_step  = accept && (geom.version != 6'd0) && seq_ok;
  end

  always_comb begin
    q_entry        = '0;
    q_entry.status = qrbcw_pkg::ST_OK;
    q_entry.count  = cw_count;
    q_entry.last   = is_last;
    unique case (hdr_n)
      2'd1:    q_entry.cw = {8'h00, body_cw, {qrbcw_pkg::MODE_BYTE, msg_len[7:4]}};
      2'd2:    q_entry.cw = {body_cw, msg_len[11:4], {qrbcw_pkg::MODE_BYTE, 4'h0}};
      default: q_entry.cw = {8'h00, 8'h00, body_cw};
    endcase
    if (geom.version == 6'd0) begin
      q_entry        = '0;
      q_entry.status = qrbcw_pkg::ST_TOO_LONG;
      q_entry.count  = 2'd1;
    end else if (!seq_ok) begin
      q_entry        = '0;
      q_entry.status = qrbcw_pkg::ST_ORDER;
      q_entry.count  = 2'd1;
    end
  end

  always_comb begin
    phase_next      = phase;
    bytes_seen_next = bytes_seen;
    cws_sent_next   = cws_sent;
    carry_next      = carry;
    pad_toggle_next = pad_toggle;
    if (do_step) begin
      cws_sent_next = cw_sum[11:0];
      if (phase == qrbcw_pkg::PH_PAD) begin
        pad_toggle_next = !pad_toggle;
      end else if (in_ch.req_type) begin
        carry_next = 4'h0;
        phase_next = qrbcw_pkg::PH_PAD;
      end else begin
        carry_next      = in_ch.data_byte[3:0];
        bytes_seen_next = bytes_seen + 12'd1;
        phase_next      = qrbcw_pkg::PH_BODY;
      end
      if (is_last) begin
        phase_next = qrbcw_pkg::PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase <= qrbcw_pkg::PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      bytes_seen <= '0;
      cws_sent   <= '0;
      carry      <= '0;
      pad_toggle <= 1'b0;
    end else begin
      bytes_seen <= bytes_seen_next;
      cws_sent   <= cws_sent_next;
      carry      <= carry_next;
      pad_toggle <= pad_toggle_next;
    end
  end

endmodule

`default_nettype wire

### sv/qrbcw_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on qrbcw_pkg.
`default_nettype none

module qrbcw_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire qrbcw_pkg::qentry_t  push_entry,
  output logic                     full,
  input  wire logic                pop,
  output qrbcw_pkg::qentry_t       head,
  output logic                     empty
);

  qrbcw_pkg::qentry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/qrbcw_back.sv
// Back end: sends queued codewords one per beat and tags block and position.
// Depends on qrbcw_pkg and qrbcw_out_if.
`default_nettype none

module qrbcw_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                restart,
  input  wire qrbcw_pkg::geom_t    geom,
  input  wire logic                q_empty,
  input  wire qrbcw_pkg::qentry_t  head,
  output logic                     q_pop,
  qrbcw_out_if.source              out_ch
);

  logic [1:0] sub;
  logic [5:0] blk;
  logic [5:0] pos;
  logic [5:0] blen;
  logic [5:0] pos_inc;
  logic [7:0] cur_cw;
  logic       load;
  logic       final_cw;
  logic       is_ok;

  logic       out_valid;
  logic [7:0] out_codeword;
  logic [5:0] out_block;
  logic [5:0] out_pos;
  logic [5:0] out_version;
  logic       out_last;
  logic [1:0] out_status;

  always_comb begin
    unique case (sub)
      2'd1:    cur_cw = head.cw[1];
      2'd2:    cur_cw = head.cw[2];
      default: cur_cw = head.cw[0];
    endcase
    load     = !q_empty && (!out_valid || out_ch.ready);
    final_cw = (sub == (head.count - 2'd1));
    is_ok    = (head.status == qrbcw_pkg::ST_OK);
    blen     = (blk < geom.short_blocks) ? geom.short_len : geom.short_len + 6'd1;
    pos_inc  = pos + 6'd1;
  end

  assign q_pop = load && final_cw;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sub <= 2'd0;
      blk <= '0;
      pos <= '0;
    end else if (load) begin
      sub <= final_cw ? 2'd0 : sub + 2'd1;
      if (is_ok) begin
        if (pos_inc >= blen) begin
          pos <= '0;
          blk <= blk + 6'd1;
        end else begin
          pos <= pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_codeword <= cur_cw;
      out_block    <= is_ok ? blk : 6'd0;
      out_pos      <= is_ok ? pos : 6'd0;
      out_version  <= geom.version;
      out_last     <= final_cw && head.last;
      out_status   <= head.status;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.codeword          = out_codeword;
  assign out_ch.block_index       = out_block;
  assign out_ch.position_in_block = out_pos;
  assign out_ch.symbol_version    = out_version;
  assign out_ch.last              = out_last;
  assign out_ch.status            = out_status;

endmodule

`default_nettype wire
